@@ hw/rtl/shtr_pkg.sv @@
// shared types, constants and helper functions for the timestamp recovery block
`timescale 1ns / 1ps
`default_nettype none

package shtr_pkg;

    // field widths
    localparam int TIME_W     = 64;
    localparam int HOST_W     = 63;
    localparam int HUB_W      = 53;
    localparam int STAMP_W    = 24;
    localparam int LAT_W      = 32;
    localparam int NUDGE_W    = 24;
    localparam int DIR_W      = 2;
    localparam int OPCODE_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // width of the hub microsecond counter that rolls over
    localparam int SHORT_TIME_BITS = 28;
    localparam int HI_W            = TIME_W - SHORT_TIME_BITS;

    // a short stamp counts 16 us units
    localparam int STAMP_SHIFT = 4;

    localparam logic [TIME_W-1:0] ROLL_THRESHOLD_US = 64'd130000000;
    localparam int                NS_PER_US         = 1000;

    // config reset values
    localparam logic [LAT_W-1:0]   MAX_LAT_RESET = 32'd100000000;
    localparam logic [LAT_W-1:0]   MIN_LAT_RESET = 32'd200000;
    localparam logic [NUDGE_W-1:0] NUDGE_RESET   = 24'd50000;

    // divide by 1000, one 16-bit digit per step
    localparam int DIGIT_W     = 16;
    localparam int DIGITS      = TIME_W / DIGIT_W;
    localparam int REM_W       = 10;
    localparam int DX_W        = REM_W + DIGIT_W;
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = DX_W + REM_W;
    localparam logic [RECIP_W-1:0] RECIP = 27'd68719476;

    // nudge direction codes
    localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'b01;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'b11;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SYNC    = 2'd0,
        OP_RECOVER = 2'd1,
        OP_DRIFT   = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_LATENCY = 2'd0,
        REG_MIN_LATENCY = 2'd1,
        REG_NUDGE       = 2'd2
    } cfg_reg_t;

    // per-item data that rides alongside the divider
    typedef struct packed {
        op_t                        op;
        logic [DIR_W-1:0]           dir;
        logic [TIME_W-1:0]          offset;
        logic [SHORT_TIME_BITS-1:0] stamp;
        logic                       neg;
    } side_t;

    // x * 1000 as 1024 - 16 - 8, modulo 2^64
    function automatic logic [TIME_W-1:0] mul1000_time(input logic [TIME_W-1:0] a);
        return (a << 10) - (a << 4) - (a << 3);
    endfunction

    // same on a divider step word
    function automatic logic [DX_W-1:0] mul1000_dx(input logic [DX_W-1:0] a);
        return (a << 10) - (a << 4) - (a << 3);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/shtr_div1000.sv @@
// pipelined unsigned divide by 1000, one 16-bit quotient digit per two stages
`timescale 1ns / 1ps
`default_nettype none

module shtr_div1000 (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [shtr_pkg::TIME_W-1:0]      in_mag,
    input  shtr_pkg::side_t                  in_side,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [shtr_pkg::TIME_W-1:0]      out_quot,
    output shtr_pkg::side_t                  out_side
);

    localparam int NDIG  = shtr_pkg::DIGITS;
    localparam int TW    = shtr_pkg::TIME_W;
    localparam int DW    = shtr_pkg::DIGIT_W;
    localparam int XW    = shtr_pkg::DX_W;
    localparam int RW    = shtr_pkg::REM_W;
    localparam int PW    = shtr_pkg::DX_W + shtr_pkg::RECIP_W;

    // multiply stage registers
    logic                    mul_valid_reg [NDIG];
    logic [XW-1:0]           mul_x_reg     [NDIG];
    logic [DW-1:0]           mul_q0_reg    [NDIG];
    logic [TW-1:0]           mul_quot_reg  [NDIG];
    shtr_pkg::side_t         mul_side_reg  [NDIG];
    logic [TW-1:0]           mul_mag_reg   [NDIG-1];

    // fix-up stage registers
    logic                    fix_valid_reg [NDIG];
    logic [RW-1:0]           fix_rem_reg   [NDIG];
    logic [TW-1:0]           fix_quot_reg  [NDIG];
    shtr_pkg::side_t         fix_side_reg  [NDIG];
    logic [TW-1:0]           fix_mag_reg   [NDIG-1];

    logic                    mul_ready [NDIG];
    logic                    fix_ready [NDIG];

    genvar d;
    generate
        for (d = 0; d < NDIG; d++) begin : g_digit
            logic                v_in;
            logic [RW-1:0]       rem_in;
            logic [TW-1:0]       mag_in;
            logic [TW-1:0]       quot_in;
            shtr_pkg::side_t     side_in;
            logic [DW-1:0]       chunk;
            logic [XW-1:0]       x_in;
            logic [PW-1:0]       prod;
            logic [XW-1:0]       back;
            logic [XW-1:0]       r0;
            logic [XW-1:0]       r_fix;
            logic                over;
            logic [DW-1:0]       digit;
            logic                fix_next_ready;

            // source of this step: the transaction input or the previous fix-up
            if (d == 0) begin : g_first
                assign v_in    = in_valid;
                assign rem_in  = '0;
                assign mag_in  = in_mag;
                assign quot_in = '0;
                assign side_in = in_side;
                assign in_ready = mul_ready[0];
            end else begin : g_next
                assign v_in    = fix_valid_reg[d-1];
                assign rem_in  = fix_rem_reg[d-1];
                assign mag_in  = fix_mag_reg[d-1];
                assign quot_in = fix_quot_reg[d-1];
                assign side_in = fix_side_reg[d-1];
            end

            if (d == NDIG - 1) begin : g_last_rdy
                assign fix_next_ready = out_ready;
            end else begin : g_mid_rdy
                assign fix_next_ready = mul_ready[d+1];
            end

            // partial remainder with the next dividend digit, times reciprocal
            assign chunk = mag_in[TW-1-d*DW -: DW];
            assign x_in  = {rem_in, chunk};
            assign prod  = {{shtr_pkg::RECIP_W{1'b0}}, x_in}
                         * {{XW{1'b0}}, shtr_pkg::RECIP};

            assign mul_ready[d] = !mul_valid_reg[d] || fix_ready[d];
            assign fix_ready[d] = !fix_valid_reg[d] || fix_next_ready;

            // multiply stage
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    mul_valid_reg[d] <= 1'b0;
                end else if (mul_ready[d]) begin
                    mul_valid_reg[d] <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (v_in && mul_ready[d]) begin
                    mul_x_reg[d]    <= x_in;
                    mul_q0_reg[d]   <= prod[shtr_pkg::RECIP_SHIFT +: DW];
                    mul_quot_reg[d] <= quot_in;
                    mul_side_reg[d] <= side_in;
                end
            end

            // estimate is low by at most one: one compare and subtract
            assign back  = shtr_pkg::mul1000_dx({{RW{1'b0}}, mul_q0_reg[d]});
            assign r0    = mul_x_reg[d] - back;
            assign over  = (r0 >= XW'(shtr_pkg::NS_PER_US));
            assign r_fix = over ? (r0 - XW'(shtr_pkg::NS_PER_US)) : r0;
            assign digit = mul_q0_reg[d] + {{(DW-1){1'b0}}, over};

            // fix-up stage
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    fix_valid_reg[d] <= 1'b0;
                end else if (fix_ready[d]) begin
                    fix_valid_reg[d] <= mul_valid_reg[d];
                end
            end

            always_ff @(posedge aclk) begin
                if (mul_valid_reg[d] && fix_ready[d]) begin
                    fix_rem_reg[d]  <= r_fix[RW-1:0];
                    fix_quot_reg[d] <= {mul_quot_reg[d][TW-DW-1:0], digit};
                    fix_side_reg[d] <= mul_side_reg[d];
                end
            end

            // dividend carried only while digits remain
            if (d < NDIG - 1) begin : g_mag
                always_ff @(posedge aclk) begin
                    if (v_in && mul_ready[d]) begin
                        mul_mag_reg[d] <= mag_in;
                    end
                end

                always_ff @(posedge aclk) begin
                    if (mul_valid_reg[d] && fix_ready[d]) begin
                        fix_mag_reg[d] <= mul_mag_reg[d];
                    end
                end
            end
        end
    endgenerate

    assign out_valid = fix_valid_reg[NDIG-1];
    assign out_quot  = fix_quot_reg[NDIG-1];
    assign out_side  = fix_side_reg[NDIG-1];

endmodule

`default_nettype wire

@@ hw/rtl/sensor_hub_timestamp_recovery_core.sv @@
// top level: offset tracking, drift nudging and rollover-corrected timestamp recovery
// Every opcode passes through every stage, from the input register to the output register.
// Throughput: one transaction per cycle; every stage holds its item on back-pressure
// and empty stages fill behind a stalled result, so the input keeps taking items.
// The divide by 1000 takes eight of those stages (four 16-bit digits, two stages each).
// Reset: pipeline empties, offset clears to zero, latency and nudge registers
// return to their defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sensor_hub_timestamp_recovery_core (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    // input transactions
    input  wire                                    s_valid,
    output logic                                   s_ready,
    input  wire  [shtr_pkg::OPCODE_W-1:0]          s_opcode,
    input  wire  [shtr_pkg::HOST_W-1:0]            s_host_time_ns,
    input  wire  [shtr_pkg::HUB_W-1:0]             s_hub_elapsed_us,
    input  wire  [shtr_pkg::STAMP_W-1:0]           s_hub_short_stamp,
    input  wire  signed [shtr_pkg::TIME_W-1:0]     s_recovered_time_ns,
    input  wire                                    s_is_streaming,
    // result transactions
    output logic                                   m_valid,
    input  wire                                    m_ready,
    output logic signed [shtr_pkg::TIME_W-1:0]     m_full_time_ns,
    output logic signed [shtr_pkg::DIR_W-1:0]      m_nudge_direction,
    // register writes
    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire  [shtr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire  [shtr_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int TW  = shtr_pkg::TIME_W;
    localparam int STB = shtr_pkg::SHORT_TIME_BITS;
    localparam int HW  = shtr_pkg::HI_W;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [shtr_pkg::LAT_W-1:0]   max_lat_reg;
    logic [shtr_pkg::LAT_W-1:0]   min_lat_reg;
    logic [shtr_pkg::NUDGE_W-1:0] nudge_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_lat_reg <= shtr_pkg::MAX_LAT_RESET;
            min_lat_reg <= shtr_pkg::MIN_LAT_RESET;
            nudge_reg   <= shtr_pkg::NUDGE_RESET;
        end else if (cfg_valid) begin
            case (shtr_pkg::cfg_reg_t'(cfg_index))
                shtr_pkg::REG_MAX_LATENCY: max_lat_reg <= cfg_data;
                shtr_pkg::REG_MIN_LATENCY: min_lat_reg <= cfg_data;
                shtr_pkg::REG_NUDGE:       nudge_reg   <= cfg_data[shtr_pkg::NUDGE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // ready chain, each stage moves when it is empty or its successor moves
    // ---------------------------------------------------------------
    logic in_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg, s7_valid_reg, out_valid_reg;
    logic in_rdy, s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, s6_rdy, s7_rdy, out_rdy;
    logic div_in_ready, div_out_valid;

    assign out_rdy = !out_valid_reg || m_ready;
    assign s7_rdy  = !s7_valid_reg  || out_rdy;
    assign s6_rdy  = !s6_valid_reg  || s7_rdy;
    assign s5_rdy  = !s5_valid_reg  || s6_rdy;
    assign s4_rdy  = !s4_valid_reg  || s5_rdy;
    assign s3_rdy  = !s3_valid_reg  || div_in_ready;
    assign s2_rdy  = !s2_valid_reg  || s3_rdy;
    assign s1_rdy  = !s1_valid_reg  || s2_rdy;
    assign in_rdy  = !in_valid_reg  || s1_rdy;

    assign s_ready = in_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_rdy)  in_valid_reg  <= s_valid;
            if (s1_rdy)  s1_valid_reg  <= in_valid_reg;
            if (s2_rdy)  s2_valid_reg  <= s1_valid_reg;
            if (s3_rdy)  s3_valid_reg  <= s2_valid_reg;
            if (s4_rdy)  s4_valid_reg  <= div_out_valid;
            if (s5_rdy)  s5_valid_reg  <= s4_valid_reg;
            if (s6_rdy)  s6_valid_reg  <= s5_valid_reg;
            if (s7_rdy)  s7_valid_reg  <= s6_valid_reg;
            if (out_rdy) out_valid_reg <= s7_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // input register
    // ---------------------------------------------------------------
    shtr_pkg::op_t                 in_op_reg;
    logic [shtr_pkg::HOST_W-1:0]   in_host_reg;
    logic [shtr_pkg::HUB_W-1:0]    in_hub_reg;
    logic [shtr_pkg::STAMP_W-1:0]  in_stamp_reg;
    logic [TW-1:0]                 in_rec_reg;
    logic                          in_stream_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && in_rdy) begin
            in_op_reg     <= shtr_pkg::op_t'(s_opcode);
            in_host_reg   <= s_host_time_ns;
            in_hub_reg    <= s_hub_elapsed_us;
            in_stamp_reg  <= s_hub_short_stamp;
            in_rec_reg    <= s_recovered_time_ns;
            in_stream_reg <= s_is_streaming;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: hub time in ns, latency compares, stamp in us
    // ---------------------------------------------------------------
    logic [TW-1:0]   hub_ns;
    logic [TW-1:0]   latency;
    logic [TW-1:0]   stamp_wide;
    logic            raise, lower;

    assign hub_ns     = shtr_pkg::mul1000_time({{(TW-shtr_pkg::HUB_W){1'b0}}, in_hub_reg});
    assign latency    = {{(TW-shtr_pkg::HOST_W){1'b0}}, in_host_reg} - in_rec_reg;
    assign raise      = in_stream_reg && ($signed(latency) >
                        $signed({{(TW-shtr_pkg::LAT_W){1'b0}}, max_lat_reg}));
    assign lower      = $signed(latency) <
                        $signed({{(TW-shtr_pkg::LAT_W){1'b0}}, min_lat_reg});
    assign stamp_wide = {{(TW-shtr_pkg::STAMP_W-shtr_pkg::STAMP_SHIFT){1'b0}},
                         in_stamp_reg, {shtr_pkg::STAMP_SHIFT{1'b0}}};

    shtr_pkg::op_t                 s1_op_reg;
    logic [shtr_pkg::HOST_W-1:0]   s1_host_reg;
    logic [TW-1:0]                 s1_hub_ns_reg;
    logic                          s1_raise_reg, s1_lower_reg;
    logic [STB-1:0]                s1_stamp_reg;

    always_ff @(posedge aclk) begin
        if (in_valid_reg && s1_rdy) begin
            s1_op_reg     <= in_op_reg;
            s1_host_reg   <= in_host_reg;
            s1_hub_ns_reg <= hub_ns;
            s1_raise_reg  <= raise;
            s1_lower_reg  <= lower;
            s1_stamp_reg  <= stamp_wide[STB-1:0];
        end
    end

    // ---------------------------------------------------------------
    // stage 2: offset update (sync and drift), host minus offset for recover
    // ---------------------------------------------------------------
    logic [TW-1:0]               offset_reg, offset_next;
    logic [shtr_pkg::DIR_W-1:0]  dir;
    logic [TW-1:0]               host_ext;
    logic [TW-1:0]               nudge_ext;
    logic [TW-1:0]               hub_diff;

    assign host_ext  = {{(TW-shtr_pkg::HOST_W){1'b0}}, s1_host_reg};
    assign nudge_ext = {{(TW-shtr_pkg::NUDGE_W){1'b0}}, nudge_reg};
    assign hub_diff  = host_ext - offset_reg;

    always_comb begin
        offset_next = offset_reg;
        dir         = shtr_pkg::DIR_NONE;
        case (s1_op_reg)
            shtr_pkg::OP_SYNC: begin
                offset_next = host_ext - s1_hub_ns_reg;
            end
            shtr_pkg::OP_DRIFT: begin
                if (s1_raise_reg) begin
                    offset_next = offset_reg + nudge_ext;
                    dir         = shtr_pkg::DIR_UP;
                end else if (s1_lower_reg) begin
                    offset_next = offset_reg - nudge_ext;
                    dir         = shtr_pkg::DIR_DOWN;
                end
            end
            default: ;
        endcase
    end

    shtr_pkg::side_t  s2_side_reg;
    logic [TW-1:0]    s2_diff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (s1_valid_reg && s2_rdy) begin
            offset_reg <= offset_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s2_rdy) begin
            s2_side_reg.op     <= s1_op_reg;
            s2_side_reg.dir    <= dir;
            s2_side_reg.offset <= offset_reg;
            s2_side_reg.stamp  <= s1_stamp_reg;
            s2_side_reg.neg    <= hub_diff[TW-1];
            s2_diff_reg        <= hub_diff;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: magnitude for the divider
    // ---------------------------------------------------------------
    shtr_pkg::side_t  s3_side_reg;
    logic [TW-1:0]    s3_mag_reg;

    always_ff @(posedge aclk) begin
        if (s2_valid_reg && s3_rdy) begin
            s3_side_reg <= s2_side_reg;
            s3_mag_reg  <= s2_side_reg.neg ? (TW'(0) - s2_diff_reg) : s2_diff_reg;
        end
    end

    // ---------------------------------------------------------------
    // divide by 1000
    // ---------------------------------------------------------------
    logic [TW-1:0]    div_quot;
    shtr_pkg::side_t  div_side;

    shtr_div1000 u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s3_valid_reg),
        .in_ready  (div_in_ready),
        .in_mag    (s3_mag_reg),
        .in_side   (s3_side_reg),
        .out_valid (div_out_valid),
        .out_ready (s4_rdy),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // ---------------------------------------------------------------
    // stage 4: restore sign, truncation toward zero
    // ---------------------------------------------------------------
    shtr_pkg::side_t  s4_side_reg;
    logic [TW-1:0]    s4_est_reg;

    always_ff @(posedge aclk) begin
        if (div_out_valid && s4_rdy) begin
            s4_side_reg <= div_side;
            s4_est_reg  <= div_side.neg ? (TW'(0) - div_quot) : div_quot;
        end
    end

    // ---------------------------------------------------------------
    // stage 5: rollover detection against the short stamp
    // ---------------------------------------------------------------
    logic [STB:0]   d_fwd, d_back;
    logic           roll_fwd, roll_back;

    assign d_fwd     = {1'b0, s4_est_reg[STB-1:0]} - {1'b0, s4_side_reg.stamp};
    assign d_back    = {1'b0, s4_side_reg.stamp} - {1'b0, s4_est_reg[STB-1:0]};
    assign roll_fwd  = $signed({{(TW-STB-1){d_fwd[STB]}}, d_fwd})
                     > $signed(shtr_pkg::ROLL_THRESHOLD_US);
    assign roll_back = $signed({{(TW-STB-1){d_back[STB]}}, d_back})
                     > $signed(shtr_pkg::ROLL_THRESHOLD_US);

    shtr_pkg::side_t  s5_side_reg;
    logic [HW-1:0]    s5_hi_reg;
    logic             s5_fwd_reg, s5_back_reg;

    always_ff @(posedge aclk) begin
        if (s4_valid_reg && s5_rdy) begin
            s5_side_reg <= s4_side_reg;
            s5_hi_reg   <= s4_est_reg[TW-1:STB];
            s5_fwd_reg  <= roll_fwd;
            s5_back_reg <= roll_back && !roll_fwd;
        end
    end

    // ---------------------------------------------------------------
    // stage 6: move a whole period and splice in the stamp
    // ---------------------------------------------------------------
    logic [HW-1:0] hi_adj;

    always_comb begin
        hi_adj = s5_hi_reg;
        if (s5_fwd_reg) begin
            hi_adj = s5_hi_reg + HW'(1);
        end else if (s5_back_reg) begin
            hi_adj = s5_hi_reg - HW'(1);
        end
    end

    shtr_pkg::side_t  s6_side_reg;
    logic [TW-1:0]    s6_us_reg;

    always_ff @(posedge aclk) begin
        if (s5_valid_reg && s6_rdy) begin
            s6_side_reg <= s5_side_reg;
            s6_us_reg   <= {hi_adj, s5_side_reg.stamp};
        end
    end

    // ---------------------------------------------------------------
    // stage 7: back to nanoseconds
    // ---------------------------------------------------------------
    shtr_pkg::side_t  s7_side_reg;
    logic [TW-1:0]    s7_ns_reg;

    always_ff @(posedge aclk) begin
        if (s6_valid_reg && s7_rdy) begin
            s7_side_reg <= s6_side_reg;
            s7_ns_reg   <= shtr_pkg::mul1000_time(s6_us_reg);
        end
    end

    // ---------------------------------------------------------------
    // output register: add the offset, zero for anything but recover
    // ---------------------------------------------------------------
    logic [TW-1:0]               out_full_reg;
    logic [shtr_pkg::DIR_W-1:0]  out_dir_reg;

    always_ff @(posedge aclk) begin
        if (s7_valid_reg && out_rdy) begin
            out_full_reg <= (s7_side_reg.op == shtr_pkg::OP_RECOVER)
                          ? (s7_ns_reg + s7_side_reg.offset) : '0;
            out_dir_reg  <= s7_side_reg.dir;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_full_time_ns    = out_full_reg;
    assign m_nudge_direction = out_dir_reg;

endmodule

`default_nettype wire

@@ tb/tb_sensor_hub_timestamp_recovery_core.sv @@
// self-checking testbench for the sensor hub timestamp recovery core
`timescale 1ns / 1ps

module tb_sensor_hub_timestamp_recovery_core;

    // field widths taken from the package
    localparam int OPCODE_W        = shtr_pkg::OPCODE_W;
    localparam int HOST_W          = shtr_pkg::HOST_W;
    localparam int HUB_W           = shtr_pkg::HUB_W;
    localparam int STAMP_W         = shtr_pkg::STAMP_W;
    localparam int TIME_W          = shtr_pkg::TIME_W;
    localparam int DIR_W           = shtr_pkg::DIR_W;
    localparam int LAT_W           = shtr_pkg::LAT_W;
    localparam int NUDGE_W         = shtr_pkg::NUDGE_W;
    localparam int CFG_IDX_W       = shtr_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W      = shtr_pkg::CFG_DATA_W;
    localparam int SHORT_TIME_BITS = shtr_pkg::SHORT_TIME_BITS;

    // opcode with no operation behind it
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [63:0]        HUB_WRAP_MASK = (64'd1 << SHORT_TIME_BITS) - 64'd1;
    localparam logic [63:0]        HUB_PERIOD    = 64'd1 << SHORT_TIME_BITS;
    localparam logic signed [63:0] ROLL_LIMIT    = 64'sd130000000;

    typedef struct packed {
        logic [TIME_W-1:0] full_ns;
        logic [DIR_W-1:0]  dir;
    } hub_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                          s_valid             = 1'b0;
    logic                          s_ready;
    logic [OPCODE_W-1:0]           s_opcode            = '0;
    logic [HOST_W-1:0]             s_host_time_ns      = '0;
    logic [HUB_W-1:0]              s_hub_elapsed_us    = '0;
    logic [STAMP_W-1:0]            s_hub_short_stamp   = '0;
    logic signed [TIME_W-1:0]      s_recovered_time_ns = '0;
    logic                          s_is_streaming      = 1'b0;
    logic                          m_valid;
    logic                          m_ready             = 1'b0;
    logic signed [TIME_W-1:0]      m_full_time_ns;
    logic signed [DIR_W-1:0]       m_nudge_direction;
    logic                          cfg_valid           = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index           = '0;
    logic [CFG_DATA_W-1:0]         cfg_data            = '0;

    // shadow copy of the block's registers and offset
    logic [LAT_W-1:0]   max_lat_q;
    logic [LAT_W-1:0]   min_lat_q;
    logic [NUDGE_W-1:0] nudge_q;
    logic [TIME_W-1:0]  offset_ns;

    hub_result_t pending_results[$];
    int          errors  = 0;
    bit          no_gaps = 1'b0;

    sensor_hub_timestamp_recovery_core dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_opcode            (s_opcode),
        .s_host_time_ns      (s_host_time_ns),
        .s_hub_elapsed_us    (s_hub_elapsed_us),
        .s_hub_short_stamp   (s_hub_short_stamp),
        .s_recovered_time_ns (s_recovered_time_ns),
        .s_is_streaming      (s_is_streaming),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_full_time_ns      (m_full_time_ns),
        .m_nudge_direction   (m_nudge_direction),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [HOST_W-1:0] rand_host();
        return HOST_W'(rand64());
    endfunction

    function automatic logic [HUB_W-1:0] rand_hub();
        return HUB_W'(rand64());
    endfunction

    function automatic logic [STAMP_W-1:0] rand_stamp();
        return STAMP_W'($urandom);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom);
    endfunction

    // widen a 16 us hub stamp to host nanoseconds, fixing a counter wrap either way
    function automatic logic [TIME_W-1:0] widen_stamp(input logic [HOST_W-1:0] host,
                                                      input logic [STAMP_W-1:0] short_stamp);
        logic [63:0]        stamp_us;
        logic [63:0]        est;
        logic [63:0]        short_est;
        logic signed [63:0] ahead;
        logic signed [63:0] behind;
        stamp_us  = {36'd0, short_stamp, 4'd0};
        est       = $signed({1'b0, host} - offset_ns) / 64'sd1000;
        short_est = est & HUB_WRAP_MASK;
        ahead     = short_est - stamp_us;
        behind    = stamp_us - short_est;
        if (ahead > ROLL_LIMIT)
            est = est + HUB_PERIOD;
        else if (behind > ROLL_LIMIT)
            est = est - HUB_PERIOD;
        return ((est & ~HUB_WRAP_MASK) | stamp_us) * 64'd1000 + offset_ns;
    endfunction

    // latency check against the window, nudging the offset
    function automatic logic [DIR_W-1:0] predict_drift(input logic [HOST_W-1:0] host,
                                                       input logic [TIME_W-1:0] rec,
                                                       input logic strm);
        logic signed [63:0] latency;
        latency = {1'b0, host} - rec;
        if (strm && latency > $signed({32'd0, max_lat_q})) begin
            offset_ns = offset_ns + {40'd0, nudge_q};
            return shtr_pkg::DIR_UP;
        end
        if (latency < $signed({32'd0, min_lat_q})) begin
            offset_ns = offset_ns - {40'd0, nudge_q};
            return shtr_pkg::DIR_DOWN;
        end
        return shtr_pkg::DIR_NONE;
    endfunction

    // expected result of one transaction, advancing the shadow offset
    function automatic hub_result_t compute_hub_result(input logic [OPCODE_W-1:0] op,
                                                       input logic [HOST_W-1:0] host,
                                                       input logic [HUB_W-1:0] hub,
                                                       input logic [STAMP_W-1:0] stamp,
                                                       input logic [TIME_W-1:0] rec,
                                                       input logic strm);
        hub_result_t res;
        res.full_ns = '0;
        res.dir     = shtr_pkg::DIR_NONE;
        case (op)
            shtr_pkg::OP_SYNC:    offset_ns = {1'b0, host} - {11'd0, hub} * 64'd1000;
            shtr_pkg::OP_RECOVER: res.full_ns = widen_stamp(host, stamp);
            shtr_pkg::OP_DRIFT:   res.dir = predict_drift(host, rec, strm);
            default: ;
        endcase
        return res;
    endfunction

    // present one transaction after a random gap, predict it once accepted
    task automatic send_request(input logic [OPCODE_W-1:0] op,
                                input logic [HOST_W-1:0] host,
                                input logic [HUB_W-1:0] hub,
                                input logic [STAMP_W-1:0] stamp,
                                input logic [TIME_W-1:0] rec,
                                input logic strm);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_opcode            <= op;
        s_host_time_ns      <= host;
        s_hub_elapsed_us    <= hub;
        s_hub_short_stamp   <= stamp;
        s_recovered_time_ns <= rec;
        s_is_streaming      <= strm;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(compute_hub_result(op, host, hub, stamp, rec, strm));
    endtask

    // stop sending until every outstanding result is back
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // write all three registers back to back while the block is idle
    task automatic load_drift_config(input logic [LAT_W-1:0] max_ns,
                                     input logic [LAT_W-1:0] min_ns,
                                     input logic [NUDGE_W-1:0] step_ns);
        shtr_pkg::cfg_reg_t    regs [3];
        logic [CFG_DATA_W-1:0] vals [3];
        regs = '{shtr_pkg::REG_MAX_LATENCY, shtr_pkg::REG_MIN_LATENCY, shtr_pkg::REG_NUDGE};
        vals = '{max_ns, min_ns, {8'd0, step_ns}};
        wait_results_drained();
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            case (regs[i])
                shtr_pkg::REG_MAX_LATENCY: max_lat_q = vals[i];
                shtr_pkg::REG_MIN_LATENCY: min_lat_q = vals[i];
                default:                   nudge_q   = vals[i][NUDGE_W-1:0];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // result side: random stall before each transaction
    initial begin
        int stall;
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_valid));
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : check_results
        hub_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing outstanding: full_time_ns %0d",
                       m_full_time_ns);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_full_time_ns !== $signed(want.full_ns)) begin
                    $error("full_time_ns mismatch: expected %0d, actual %0d",
                           $signed(want.full_ns), m_full_time_ns);
                    errors++;
                end
                if (m_nudge_direction !== $signed(want.dir)) begin
                    $error("nudge_direction mismatch: expected %0d, actual %0d",
                           $signed(want.dir), m_nudge_direction);
                    errors++;
                end
            end
        end
    end

    // default window after reset, zero offset
    task automatic test_reset_defaults();
        send_request(shtr_pkg::OP_RECOVER, '0, rand_hub(), '0, rand64(), 1'b0);
        send_request(shtr_pkg::OP_RECOVER, {HOST_W{1'b1}}, rand_hub(), {STAMP_W{1'b1}},
                     rand64(), 1'b1);
        send_request(shtr_pkg::OP_DRIFT, 63'd1000000000, rand_hub(), rand_stamp(),
                     64'd899999999, 1'b1);
        send_request(shtr_pkg::OP_DRIFT, 63'd1000000000, rand_hub(), rand_stamp(),
                     64'd900000000, 1'b1);
        send_request(shtr_pkg::OP_DRIFT, 63'd1000000000, rand_hub(), rand_stamp(),
                     64'd999800001, 1'b0);
        send_request(shtr_pkg::OP_DRIFT, 63'd1000000000, rand_hub(), rand_stamp(),
                     64'd999800000, 1'b1);
    endtask

    // sync at the corners of host and hub time
    task automatic test_sync_extremes();
        send_request(shtr_pkg::OP_SYNC, {HOST_W{1'b1}}, {HUB_W{1'b1}}, rand_stamp(),
                     rand64(), 1'b1);
        send_request(shtr_pkg::OP_RECOVER, {HOST_W{1'b1}}, rand_hub(), '0, rand64(), 1'b0);
        send_request(shtr_pkg::OP_SYNC, '0, '0, rand_stamp(), rand64(), 1'b0);
        send_request(shtr_pkg::OP_SYNC, '0, {HUB_W{1'b1}}, rand_stamp(), rand64(), 1'b0);
        send_request(shtr_pkg::OP_RECOVER, '0, rand_hub(), 24'h800001, rand64(), 1'b1);
    endtask

    // wrap forward, wrap back, exactly on the limit, negative estimate
    task automatic test_recover_rollover();
        logic [63:0] h;
        send_request(shtr_pkg::OP_SYNC, '0, '0, rand_stamp(), rand64(), 1'b0);
        h = ((64'd5 << SHORT_TIME_BITS) + 64'd194000001) * 64'd1000;
        send_request(shtr_pkg::OP_RECOVER, h[HOST_W-1:0], rand_hub(), 24'd4000000,
                     rand64(), 1'b0);
        h = ((64'd5 << SHORT_TIME_BITS) + 64'd194000000) * 64'd1000;
        send_request(shtr_pkg::OP_RECOVER, h[HOST_W-1:0], rand_hub(), 24'd4000000,
                     rand64(), 1'b1);
        h = ((64'd5 << SHORT_TIME_BITS) + 64'd61999999) * 64'd1000;
        send_request(shtr_pkg::OP_RECOVER, h[HOST_W-1:0], rand_hub(), 24'd12000000,
                     rand64(), 1'b0);
        // host behind the offset: estimate below zero, truncated towards zero
        send_request(shtr_pkg::OP_SYNC, 63'd5000000000, '0, rand_stamp(), rand64(), 1'b1);
        send_request(shtr_pkg::OP_RECOVER, 63'd1, rand_hub(), 24'h123456, rand64(), 1'b0);
    endtask

    // negative latency lowers even when streaming
    task automatic test_drift_negative_latency();
        send_request(shtr_pkg::OP_DRIFT, '0, rand_hub(), rand_stamp(),
                     64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        send_request(shtr_pkg::OP_DRIFT, {HOST_W{1'b1}}, rand_hub(), rand_stamp(),
                     64'h8000_0000_0000_0000, 1'b1);
    endtask

    task automatic test_unused_opcode();
        send_request(OP_UNUSED, rand_host(), rand_hub(), rand_stamp(), rand64(), 1'b1);
    endtask

    // register extremes, and the upward test taking priority
    task automatic test_config_extremes();
        load_drift_config('0, '1, '1);
        send_request(shtr_pkg::OP_DRIFT, 63'd1000000000, rand_hub(), rand_stamp(),
                     64'd999999995, 1'b1);
        send_request(shtr_pkg::OP_DRIFT, 63'd1000000000, rand_hub(), rand_stamp(),
                     64'd999999995, 1'b0);
        send_request(shtr_pkg::OP_DRIFT, 63'd1000000000, rand_hub(), rand_stamp(),
                     64'd1000000000, 1'b1);
        load_drift_config('1, '0, '0);
        send_request(shtr_pkg::OP_DRIFT, 63'h2_0000_0000, rand_hub(), rand_stamp(),
                     64'h1_0000_0000, 1'b1);
        send_request(shtr_pkg::OP_DRIFT, 63'h2_0000_0000, rand_hub(), rand_stamp(),
                     64'h1_0000_0001, 1'b1);
    endtask

    // sample streams of sync, recover and drift, with some noise, over several windows
    task automatic test_random_traffic();
        logic [LAT_W-1:0]   max_set [5];
        logic [LAT_W-1:0]   min_set [5];
        logic [NUDGE_W-1:0] nudge_set [5];
        logic [63:0]        base;
        logic [63:0]        host;
        logic [63:0]        hub_now;
        logic [63:0]        est;
        logic [63:0]        stamp_us;
        logic [63:0]        lat;
        longint             jitter;
        int                 lag;
        int                 n;
        int                 sent;
        max_set   = '{shtr_pkg::MAX_LAT_RESET, '0, '1, $urandom,
                      $urandom_range(1000, 300000000)};
        min_set   = '{shtr_pkg::MIN_LAT_RESET, '0, '1, $urandom, $urandom_range(0, 1000000)};
        nudge_set = '{shtr_pkg::NUDGE_RESET, '0, '1, NUDGE_W'($urandom),
                      NUDGE_W'($urandom_range(0, 100000))};
        for (int p = 0; p < 5; p++) begin
            load_drift_config(max_set[p], min_set[p], nudge_set[p]);
            sent = 0;
            while (sent < 120) begin
                no_gaps = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 5) == 0) begin
                    // noise: any opcode, any field
                    n = $urandom_range(1, 6);
                    repeat (n)
                        send_request(OPCODE_W'($urandom_range(0, 3)), rand_host(), rand_hub(),
                                     rand_stamp(), rand64(), rand_bit());
                    sent += n;
                end else begin
                    // sync, then recover and drift pairs as the host clock runs on
                    base = rand64() >> 2;
                    lag  = $urandom_range(0, 5000000);
                    hub_now = (base / 1000 > 64'(lag)) ? base / 1000 - 64'(lag) : 64'd0;
                    send_request(shtr_pkg::OP_SYNC, base[HOST_W-1:0], hub_now[HUB_W-1:0],
                                 rand_stamp(), rand64(), rand_bit());
                    n    = $urandom_range(3, 12);
                    host = base;
                    repeat (n) begin
                        host     = host + 64'($urandom_range(0, 200000000));
                        est      = $signed(host - offset_ns) / 64'sd1000;
                        jitter   = longint'($urandom_range(0, 280000000)) - 140000000;
                        stamp_us = (est + jitter) & HUB_WRAP_MASK;
                        send_request(shtr_pkg::OP_RECOVER, host[HOST_W-1:0], rand_hub(),
                                     stamp_us[STAMP_W+3:4], rand64(), rand_bit());
                        case ($urandom_range(0, 4))
                            0:       lat = {32'd0, max_lat_q} + 64'($urandom_range(0, 4))
                                           - 64'd2;
                            1:       lat = {32'd0, min_lat_q} + 64'($urandom_range(0, 4))
                                           - 64'd2;
                            2:       lat = 64'($urandom_range(0, 400000000));
                            3:       lat = 64'd0 - 64'($urandom_range(0, 1000));
                            default: lat = rand64();
                        endcase
                        send_request(shtr_pkg::OP_DRIFT, host[HOST_W-1:0], rand_hub(),
                                     rand_stamp(), host - lat, rand_bit());
                    end
                    sent += 1 + 2 * n;
                end
                if ($urandom_range(0, 9) == 0)
                    wait_results_drained();
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        max_lat_q = shtr_pkg::MAX_LAT_RESET;
        min_lat_q = shtr_pkg::MIN_LAT_RESET;
        nudge_q   = shtr_pkg::NUDGE_RESET;
        offset_ns = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_sync_extremes();
        test_recover_rollover();
        test_drift_negative_latency();
        test_unused_opcode();
        test_config_extremes();
        test_random_traffic();
        wait_results_drained();
        repeat (40) @(posedge aclk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // hang guard
    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
